@@ design/cpf_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and arithmetic helpers of the phase-current front end.
package cpf_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_A        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_B        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CURRENT_GAIN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_WEIGHT_Q = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_WEIGHT_D = 3'd4;

  localparam logic [11:0] OFFSET_A_RESET        = 12'd2048;
  localparam logic [11:0] OFFSET_B_RESET        = 12'd2048;
  localparam logic [15:0] CURRENT_GAIN_RESET    = 16'd1690;
  localparam logic [15:0] FILTER_WEIGHT_Q_RESET = 16'd3277;
  localparam logic [15:0] FILTER_WEIGHT_D_RESET = 16'd6554;

  // 1/sqrt(3) in Q16.
  localparam logic signed [17:0] INV_SQRT3_Q16 = 18'sd37837;
  localparam logic [15:0]        QUARTER_TURN  = 16'd16384;

  typedef enum logic [3:0] {
    S_IDLE,
    S_IA,
    S_IB,
    S_WAIT_IB,
    S_BETA,
    S_WAIT_BETA,
    S_AC,
    S_BS,
    S_BC,
    S_AS,
    S_FD,
    S_FQ,
    S_WAIT_FQ,
    S_OUT
  } ctrl_state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_MUL_IA,
    OP_MUL_IB,
    OP_MUL_BETA,
    OP_MUL_AC,
    OP_MUL_BS,
    OP_MUL_BC,
    OP_MUL_AS,
    OP_MUL_FD,
    OP_MUL_FQ
  } dp_op_t;

  typedef enum logic [1:0] {
    ROM_NONE,
    ROM_SIN,
    ROM_COS
  } rom_op_t;

  typedef struct packed {
    dp_op_t  op;
    rom_op_t rom_op;
    logic    load_in;
    logic    load_out;
  } dp_cmd_t;

  function automatic logic signed [15:0] sat16(input logic signed [47:0] v);
    logic signed [15:0] r;
    if (v > 48'sd32767) begin
      r = 16'sd32767;
    end else if (v < -48'sd32768) begin
      r = -16'sd32768;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  function automatic logic signed [23:0] clamp24(input logic signed [47:0] v);
    logic signed [23:0] r;
    if (v > 48'sd8388607) begin
      r = 24'sd8388607;
    end else if (v < -48'sd8388608) begin
      r = -24'sd8388608;
    end else begin
      r = v[23:0];
    end
    return r;
  endfunction

endpackage

@@ design/cpf_intf.sv @@
`timescale 1ns / 1ps
// Valid/ready channel interfaces for sample input and current results.
interface cpf_in_if;
  logic        valid;
  logic        ready;
  logic [11:0] sample_a;
  logic [11:0] sample_b;
  logic [15:0] elec_angle;

  modport source (output valid, output sample_a, output sample_b, output elec_angle,
                  input ready);
  modport sink (input valid, input sample_a, input sample_b, input elec_angle,
                output ready);
endinterface

interface cpf_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] i_alpha;
  logic signed [15:0] i_beta;
  logic signed [15:0] i_d_filtered;
  logic signed [15:0] i_q_filtered;

  modport source (output valid, output i_alpha, output i_beta, output i_d_filtered,
                  output i_q_filtered, input ready);
  modport sink (input valid, input i_alpha, input i_beta, input i_d_filtered,
                input i_q_filtered, output ready);
endinterface

@@ design/phase_current_clarke_park_filter_unit.sv @@
`timescale 1ns / 1ps
// Top level of the phase-current Clarke/Park front end with d/q low-pass filters.
//
// Each input transaction carries two raw phase ADC codes and an electrical angle
// and yields one result transaction with alpha, beta and the filtered d and q
// currents in Q12 amps. The nine products (two phase scalings, beta, four Park
// terms and two filter updates) go one per cycle through a single shared 25x18
// multiplier, with wait states where a product or the result register needs the
// rounded result of the one before. The input is accepted again as soon as the
// result is in the output register, so a result still waiting to be taken does
// not stall the next transaction until its own result is ready. The sine table
// is a constant ROM with a registered read and needs no fill after reset. The
// user must write the configuration registers through the cfg port only while
// idle; the block itself does not enforce this.
module phase_current_clarke_park_filter_unit import cpf_pkg::*; #(
  parameter int SINE_TABLE_DEPTH = 256
) (
  input  logic                  clk,
  input  logic                  rst_n,
  cpf_in_if.sink                in_ch,
  cpf_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  dp_cmd_t cmd;

  cpf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  cpf_datapath #(
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .sample_a     (in_ch.sample_a),
    .sample_b     (in_ch.sample_b),
    .elec_angle   (in_ch.elec_angle),
    .i_alpha      (out_ch.i_alpha),
    .i_beta       (out_ch.i_beta),
    .i_d_filtered (out_ch.i_d_filtered),
    .i_q_filtered (out_ch.i_q_filtered)
  );

endmodule

@@ design/cpf_ctrl.sv @@
`timescale 1ns / 1ps
// Sequencer that walks one transaction through the shared multiplier.
module cpf_ctrl import cpf_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output dp_cmd_t cmd
);

  ctrl_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    cmd.op         = OP_NONE;
    cmd.rom_op     = ROM_NONE;
    cmd.load_in    = 1'b0;
    cmd.load_out   = 1'b0;
    in_ready       = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_IA;
        end
      end
      S_IA: begin
        cmd.op     = OP_MUL_IA;
        cmd.rom_op = ROM_SIN;
        state_nxt  = S_IB;
      end
      S_IB: begin
        cmd.op     = OP_MUL_IB;
        cmd.rom_op = ROM_COS;
        state_nxt  = S_WAIT_IB;
      end
      S_WAIT_IB:   state_nxt = S_BETA;
      S_BETA: begin
        cmd.op    = OP_MUL_BETA;
        state_nxt = S_WAIT_BETA;
      end
      S_WAIT_BETA: state_nxt = S_AC;
      S_AC: begin
        cmd.op    = OP_MUL_AC;
        state_nxt = S_BS;
      end
      S_BS: begin
        cmd.op    = OP_MUL_BS;
        state_nxt = S_BC;
      end
      S_BC: begin
        cmd.op    = OP_MUL_BC;
        state_nxt = S_AS;
      end
      S_AS: begin
        cmd.op    = OP_MUL_AS;
        state_nxt = S_FD;
      end
      S_FD: begin
        cmd.op    = OP_MUL_FD;
        state_nxt = S_FQ;
      end
      S_FQ: begin
        cmd.op    = OP_MUL_FQ;
        state_nxt = S_WAIT_FQ;
      end
      S_WAIT_FQ:   state_nxt = S_OUT;
      S_OUT: begin
        // The result register is free once its previous transaction has gone.
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default:     state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

@@ design/cpf_datapath.sv @@
`timescale 1ns / 1ps
// Datapath: configuration registers, sine table, shared multiplier and filter state.
module cpf_datapath import cpf_pkg::*; #(
  parameter int SINE_TABLE_DEPTH = 256
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  dp_cmd_t               cmd,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [11:0]           sample_a,
  input  logic [11:0]           sample_b,
  input  logic [15:0]           elec_angle,
  output logic signed [15:0]    i_alpha,
  output logic signed [15:0]    i_beta,
  output logic signed [15:0]    i_d_filtered,
  output logic signed [15:0]    i_q_filtered
);

  localparam int IDX_W = $clog2(SINE_TABLE_DEPTH);
  localparam int IX_W  = 15 + IDX_W + 1;

  // Quarter-wave entry from an odd polynomial in Q30, rounded shifts throughout.
  function automatic logic [15:0] make_entry(input int unsigned i);
    longint c0, c1, c2, c3, c4, c5;
    longint x, x2, acc;
    c0  = 64'sd1686629713;
    c1  = -64'sd693598669;
    c2  = 64'sd85569306;
    c3  = -64'sd5026995;
    c4  = 64'sd172272;
    c5  = -64'sd3864;
    x   = (longint'(i) <<< 30) / SINE_TABLE_DEPTH;
    x2  = (x * x + 64'sd536870912) >>> 30;
    acc = c5;
    acc = c4 + ((acc * x2 + 64'sd536870912) >>> 30);
    acc = c3 + ((acc * x2 + 64'sd536870912) >>> 30);
    acc = c2 + ((acc * x2 + 64'sd536870912) >>> 30);
    acc = c1 + ((acc * x2 + 64'sd536870912) >>> 30);
    acc = c0 + ((acc * x2 + 64'sd536870912) >>> 30);
    acc = (acc * x + 64'sd536870912) >>> 30;
    acc = (acc * 64'sd32767 + 64'sd536870912) >>> 30;
    if (acc < 0) begin
      acc = 0;
    end else if (acc > 32767) begin
      acc = 32767;
    end
    return acc[15:0];
  endfunction

  logic [15:0] sine_rom [SINE_TABLE_DEPTH];

  for (genvar g = 0; g < SINE_TABLE_DEPTH; g++) begin : g_rom
    assign sine_rom[g] = make_entry(g);
  end

  logic [11:0] offset_a_r, offset_b_r;
  logic [15:0] gain_r, weight_q_r, weight_d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_a_r <= OFFSET_A_RESET;
      offset_b_r <= OFFSET_B_RESET;
      gain_r     <= CURRENT_GAIN_RESET;
      weight_q_r <= FILTER_WEIGHT_Q_RESET;
      weight_d_r <= FILTER_WEIGHT_D_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_OFFSET_A:        offset_a_r <= cfg_data[11:0];
        REG_OFFSET_B:        offset_b_r <= cfg_data[11:0];
        REG_CURRENT_GAIN:    gain_r     <= cfg_data;
        REG_FILTER_WEIGHT_Q: weight_q_r <= cfg_data;
        REG_FILTER_WEIGHT_D: weight_d_r <= cfg_data;
        default: ;
      endcase
    end
  end

  logic signed [12:0] da_r, db_r;
  logic [15:0]        angle_r;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      da_r    <= $signed({1'b0, offset_a_r}) - $signed({1'b0, sample_a});
      db_r    <= $signed({1'b0, offset_b_r}) - $signed({1'b0, sample_b});
      angle_r <= elec_angle;
    end
  end

  // Sine and cosine lookup: fold the angle into the first quadrant, read the
  // table through a registered read, then apply the quarter point and the sign.
  logic [15:0]      rom_ang;
  logic [1:0]       rom_quad;
  logic [14:0]      rom_pos, rom_u;
  logic [IX_W-1:0]  rom_idx_full;
  logic [IDX_W-1:0] rom_idx;
  logic             rom_top;

  always_comb begin
    rom_ang      = (cmd.rom_op == ROM_COS) ? angle_r + QUARTER_TURN : angle_r;
    rom_quad     = rom_ang[15:14];
    rom_pos      = {1'b0, rom_ang[13:0]};
    rom_u        = rom_quad[0] ? 15'd16384 - rom_pos : rom_pos;
    rom_idx_full = (IX_W'(rom_u) * IX_W'(SINE_TABLE_DEPTH)) >> 14;
    rom_top      = rom_idx_full >= IX_W'(SINE_TABLE_DEPTH);
    rom_idx      = rom_idx_full[IDX_W-1:0];
  end

  logic [15:0]        rom_q_r;
  logic               rom_top_r, rom_neg_r;
  rom_op_t            rom_dst_r;
  logic signed [15:0] rom_mag, rom_val;
  logic signed [15:0] sn_r, cs_r;

  always_ff @(posedge clk) begin
    rom_q_r   <= sine_rom[rom_idx];
    rom_top_r <= rom_top;
    rom_neg_r <= rom_quad[1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rom_dst_r <= ROM_NONE;
    end else begin
      rom_dst_r <= cmd.rom_op;
    end
  end

  assign rom_mag = rom_top_r ? 16'sd32767 : $signed(rom_q_r);
  assign rom_val = rom_neg_r ? -rom_mag : rom_mag;

  always_ff @(posedge clk) begin
    if (rom_dst_r == ROM_SIN) begin
      sn_r <= rom_val;
    end
    if (rom_dst_r == ROM_COS) begin
      cs_r <= rom_val;
    end
  end

  // Working registers of the current transaction.
  logic signed [20:0] ia_r, ib_r;
  logic signed [15:0] alpha_r, beta_r, id_r, iq_r;
  logic signed [32:0] acc_r;
  logic signed [23:0] sd_r, sq_r;

  logic signed [22:0] beta_sum;
  logic signed [24:0] diff_d, diff_q;
  logic signed [24:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [42:0] mul_p, prod_r;
  dp_op_t             last_op_r;

  assign beta_sum = 23'(ia_r) + (23'(ib_r) <<< 1);
  assign diff_d   = (25'(id_r) <<< 8) - 25'(sd_r);
  assign diff_q   = (25'(iq_r) <<< 8) - 25'(sq_r);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.op)
      OP_MUL_IA: begin
        mul_a = 25'(da_r);
        mul_b = $signed({2'b00, gain_r});
      end
      OP_MUL_IB: begin
        mul_a = 25'(db_r);
        mul_b = $signed({2'b00, gain_r});
      end
      OP_MUL_BETA: begin
        mul_a = 25'(beta_sum);
        mul_b = INV_SQRT3_Q16;
      end
      OP_MUL_AC: begin
        mul_a = 25'(alpha_r);
        mul_b = 18'(cs_r);
      end
      OP_MUL_BS: begin
        mul_a = 25'(beta_r);
        mul_b = 18'(sn_r);
      end
      OP_MUL_BC: begin
        mul_a = 25'(beta_r);
        mul_b = 18'(cs_r);
      end
      OP_MUL_AS: begin
        mul_a = 25'(alpha_r);
        mul_b = 18'(sn_r);
      end
      OP_MUL_FD: begin
        mul_a = diff_d;
        mul_b = $signed({2'b00, weight_d_r});
      end
      OP_MUL_FQ: begin
        mul_a = diff_q;
        mul_b = $signed({2'b00, weight_q_r});
      end
      default: ;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_ff @(posedge clk) begin
    prod_r <= mul_p;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_op_r <= OP_NONE;
    end else begin
      last_op_r <= cmd.op;
    end
  end

  // Results of the product registered in the previous cycle.
  logic signed [42:0] ph_rnd;
  logic signed [47:0] filt_step;

  assign ph_rnd    = prod_r + 43'sd128;
  assign filt_step = (48'(prod_r) + 48'sd32768) >>> 16;

  always_ff @(posedge clk) begin
    unique case (last_op_r)
      OP_MUL_IA: ia_r <= ph_rnd[28:8];
      OP_MUL_IB: begin
        ib_r    <= ph_rnd[28:8];
        alpha_r <= sat16(48'(ia_r));
      end
      OP_MUL_BETA: beta_r <= sat16((48'(prod_r) + 48'sd32768) >>> 16);
      OP_MUL_AC:   acc_r  <= prod_r[32:0];
      OP_MUL_BS:   id_r   <= sat16((48'(acc_r) + 48'(prod_r) + 48'sd16384) >>> 15);
      OP_MUL_BC:   acc_r  <= prod_r[32:0];
      OP_MUL_AS:   iq_r   <= sat16((48'(acc_r) - 48'(prod_r) + 48'sd16384) >>> 15);
      default: ;
    endcase
  end

  // Filter state carries over from one transaction to the next and is cleared by reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sd_r <= '0;
      sq_r <= '0;
    end else begin
      if (last_op_r == OP_MUL_FD) begin
        sd_r <= clamp24(48'(sd_r) + filt_step);
      end
      if (last_op_r == OP_MUL_FQ) begin
        sq_r <= clamp24(48'(sq_r) + filt_step);
      end
    end
  end

  logic signed [15:0] out_alpha_r, out_beta_r, out_d_r, out_q_r;

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_alpha_r <= alpha_r;
      out_beta_r  <= beta_r;
      out_d_r     <= sat16((48'(sd_r) + 48'sd128) >>> 8);
      out_q_r     <= sat16((48'(sq_r) + 48'sd128) >>> 8);
    end
  end

  assign i_alpha      = out_alpha_r;
  assign i_beta       = out_beta_r;
  assign i_d_filtered = out_d_r;
  assign i_q_filtered = out_q_r;

endmodule

@@ design/cpf_checker.sv @@
`timescale 1ns / 1ps
// Port-level assertions of the front end and the bind that attaches them.
module cpf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_i_alpha,
  input logic [15:0] out_i_beta,
  input logic [15:0] out_i_d_filtered,
  input logic [15:0] out_i_q_filtered
);

  // A pending result holds still until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_i_alpha) && $stable(out_i_beta)
      && $stable(out_i_d_filtered) && $stable(out_i_q_filtered))
    else $error("result changed or vanished while stalled");

  // The sequencer is busy after taking a transaction and does not raise in_ready again at once.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready ##1 !in_ready)
    else $error("input accepted again while a transaction is in progress");

  a_rst_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_rst_in: assert property (@(posedge clk) !rst_n |=> in_ready)
    else $error("input not ready right after reset");

endmodule

bind phase_current_clarke_park_filter_unit cpf_checker u_cpf_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_i_alpha      (out_ch.i_alpha),
  .out_i_beta       (out_ch.i_beta),
  .out_i_d_filtered (out_ch.i_d_filtered),
  .out_i_q_filtered (out_ch.i_q_filtered)
);
